FILE: rtl/core/ssm_pkg.sv
// Shared types and constants for the sorted sequence merge block.
`default_nettype none

package ssm_pkg;

    // Width of one stored symbol.
    localparam int SYM_W = 8;

    // Width of the operation selector.
    localparam int OP_W = 2;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_empty;
        logic out_space;
        logic last_pick;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/ssm_ctrl.sv
// Controller state machine for the sorted sequence merge block.
`default_nettype none

module ssm_ctrl
    import ssm_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_in_ready,
    input  wire t_dp_stat        i_stat,
    output t_dp_cmd              o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Input beats are taken only while no merge is in progress.
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Command decode and next state.
    always_comb begin
        n_state           = r_state;
        o_cmd.load_first  = 1'b0;
        o_cmd.load_second = 1'b0;
        o_cmd.step        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        OP_LOAD_FIRST:  o_cmd.load_first  = 1'b1;
                        OP_LOAD_SECOND: o_cmd.load_second = 1'b1;
                        OP_RUN: begin
                            if (!i_stat.both_empty) begin
                                n_state = ST_MERGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                o_cmd.step = i_stat.out_space;
                if (i_stat.out_space && i_stat.last_pick) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ssm_datapath.sv
// Datapath of the sorted sequence merge block: stores, counts, heads and output register.
`default_nettype none

module ssm_datapath
    import ssm_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [SYM_W-1:0]      o_out_symbol,
    output logic                  o_out_second,
    output logic                  o_out_last
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    logic [SYM_W-1:0] r_mem_a [STORE_DEPTH];
    logic [SYM_W-1:0] r_mem_b [STORE_DEPTH];

    logic [CW-1:0]    r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [CW-1:0]    r_idx_a, r_idx_b, n_idx_a, n_idx_b;
    logic [SYM_W-1:0] r_head_a, r_head_b;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_symbol;
    logic             r_out_second;
    logic             r_out_last;

    logic             w_wr_a, w_wr_b;
    logic             w_take_a;
    logic [SW-1:0]    w_pos, w_total;
    logic             w_last;
    logic             w_space;

    // Loads append below the depth; a load into a full store is dropped.
    assign w_wr_a = i_cmd.load_first  && (r_cnt_a < DEPTH_C);
    assign w_wr_b = i_cmd.load_second && (r_cnt_b < DEPTH_C);

    // The first head wins only when strictly smaller; ties go to the second store.
    assign w_take_a = (r_idx_a < r_cnt_a) &&
                      ((r_idx_b >= r_cnt_b) || (r_head_a < r_head_b));

    // The pick is final when it is the last of both counts together.
    assign w_pos   = {1'b0, r_idx_a} + {1'b0, r_idx_b} + SW'(1);
    assign w_total = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign w_last  = (w_pos == w_total);

    assign w_space = !r_out_valid || i_out_ready;

    assign o_stat.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_stat.out_space  = w_space;
    assign o_stat.last_pick  = w_last;

    // Next counts and read indices.
    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_idx_a = r_idx_a;
        n_idx_b = r_idx_b;
        if (w_wr_a) begin
            n_cnt_a = r_cnt_a + CW'(1);
        end
        if (w_wr_b) begin
            n_cnt_b = r_cnt_b + CW'(1);
        end
        if (i_cmd.step) begin
            if (w_last) begin
                n_cnt_a = '0;
                n_cnt_b = '0;
                n_idx_a = '0;
                n_idx_b = '0;
            end else if (w_take_a) begin
                n_idx_a = r_idx_a + CW'(1);
            end else begin
                n_idx_b = r_idx_b + CW'(1);
            end
        end
    end

    // Store writes and registered head reads at the next indices.
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_symbol;
        end
        if (w_wr_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_symbol;
        end
        if (n_idx_a < DEPTH_C) begin
            r_head_a <= r_mem_a[n_idx_a[AW-1:0]];
        end
        if (n_idx_b < DEPTH_C) begin
            r_head_b <= r_mem_b[n_idx_b[AW-1:0]];
        end
    end

    // Counts and indices.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_idx_a <= '0;
            r_idx_b <= '0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_idx_a <= n_idx_a;
            r_idx_b <= n_idx_b;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_symbol <= w_take_a ? r_head_a : r_head_b;
            r_out_second <= !w_take_a;
            r_out_last   <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_symbol;
    assign o_out_second = r_out_second;
    assign o_out_last   = r_out_last;

`ifndef SYNTH
    // A read index never passes its store's count.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b))
        else $error("merge index beyond store count");

    // Counts never exceed the store depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C))
        else $error("store count beyond depth");

    // The final pick of a run clears both counts and indices.
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && w_last) |=>
        (r_cnt_a == '0) && (r_cnt_b == '0) && (r_idx_a == '0) && (r_idx_b == '0))
        else $error("run end did not clear the stores");

    // A step never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_out_ready))
        else $error("step while output register is stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sorted_sequence_merge.sv
// Top level of the sorted sequence merge block.
//
//  Channel   Dir  Payload
//  s_axis    in   tdata[7:0] symbol; tuser[1:0] op (load first, load second, run)
//  m_axis    out  tdata[7:0] merged symbol; tuser[0] from second store; tlast last
//
// Back-to-back load beats are accepted every cycle.
// A run merges one symbol per cycle while the output is not stalled, set by the single
// registered head read of each store; an empty run leaves the block idle.
// Input beats are not accepted while a merge is in progress.
// Output stalls hold the merge; the final result may wait while new beats enter.
// Reset is synchronous, active low, and empties both stores.
`default_nettype none

module sorted_sequence_merge
    import ssm_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] symbol
    input  wire logic [OP_W-1:0]  s_axis_tuser,   // [1:0] op
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] merged_symbol
    output logic [0:0]            m_axis_tuser,   // [0] from_second
    output logic                  m_axis_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssm_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_symbol     (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_symbol (m_axis_tdata),
        .o_out_second (m_axis_tuser[0]),
        .o_out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/merge_checker.sv
// Checker that predicts the merged output beats of the block and compares them.
`default_nettype none

module merge_checker
    import ssm_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] symbol
    input  wire logic [OP_W-1:0]  s_axis_tuser,   // [1:0] op
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [7:0]       m_axis_tdata,   // [7:0] merged_symbol
    input  wire logic [0:0]       m_axis_tuser,   // [0] from_second
    input  wire logic             m_axis_tlast,
    output int                    o_fail_count,
    output int                    o_pending
);

    // One predicted output beat.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             from_second;
        logic             last;
    } t_merged_beat;

    // Shadow copies of both stores and their fill levels.
    logic [SYM_W-1:0] first_copy  [STORE_DEPTH];
    logic [SYM_W-1:0] second_copy [STORE_DEPTH];
    int               first_held;
    int               second_held;
    t_merged_beat     merged_expect [$];

    // Merge both shadow stores into the queue of expected beats, then empty them.
    task automatic merge_stores();
        int           i;
        int           j;
        int           k;
        int           total;
        t_merged_beat beat;
        i = 0;
        j = 0;
        total = first_held + second_held;
        for (k = 0; k < total; k++) begin
            // The first store wins only when strictly smaller, so ties go second.
            if (i < first_held && (j >= second_held || first_copy[i] < second_copy[j])) begin
                beat.sym = first_copy[i];
                beat.from_second = 1'b0;
                i++;
            end else begin
                beat.sym = second_copy[j];
                beat.from_second = 1'b1;
                j++;
            end
            beat.last = (k == total - 1);
            merged_expect.push_back(beat);
        end
        first_held = 0;
        second_held = 0;
    endtask

    // Compare each accepted output beat, then fold each accepted input beat into the copy.
    always @(posedge i_clk) begin
        t_merged_beat want;
        if (!i_rst_n) begin
            first_held = 0;
            second_held = 0;
            merged_expect.delete();
            o_pending = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (merged_expect.size() == 0) begin
                    $error("unexpected output beat: merged_symbol %0d", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = merged_expect.pop_front();
                    if (m_axis_tdata !== want.sym) begin
                        $error("merged_symbol: expected %0d, actual %0d",
                               want.sym, m_axis_tdata);
                        o_fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.from_second) begin
                        $error("from_second: expected %0d, actual %0d",
                               want.from_second, m_axis_tuser[0]);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_LOAD_FIRST: begin
                        if (first_held < STORE_DEPTH) begin
                            first_copy[first_held] = s_axis_tdata;
                            first_held++;
                        end
                    end
                    OP_LOAD_SECOND: begin
                        if (second_held < STORE_DEPTH) begin
                            second_copy[second_held] = s_axis_tdata;
                            second_held++;
                        end
                    end
                    OP_RUN: begin
                        merge_stores();
                    end
                    default: begin
                    end
                endcase
            end
            o_pending = merged_expect.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench top for the sorted sequence merge block: stimulus, flow control and verdict.
`default_nettype none

module tb
    import ssm_pkg::*;
();

    localparam int STORE_DEPTH = 32;
    localparam int TARGET_ITEMS = 230;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Operation code that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;   // [7:0] symbol
    logic [OP_W-1:0]  s_axis_tuser;   // [1:0] op
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;   // [7:0] merged_symbol
    logic [0:0]       m_axis_tuser;   // [0] from_second
    logic             m_axis_tlast;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit quiet;
    bit hold_off_armed;
    bit hold_off_done;

    sorted_sequence_merge #(.STORE_DEPTH(STORE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    merge_checker #(.STORE_DEPTH(STORE_DEPTH)) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one input beat, with an occasional gap first, and wait until it is taken.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [7:0] sym);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= sym;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Next symbol of a store's contents: ascending with small steps, or anything at all.
    function automatic logic [7:0] next_symbol(input logic [7:0] prev, input bit scrambled,
                                               input bit head);
        int step;
        if (scrambled) return 8'($urandom_range(255));
        if (head) return ($urandom_range(3) == 0) ? 8'($urandom_range(200, 255))
                                                 : 8'($urandom_range(60));
        step = $urandom_range(12);
        return (int'(prev) + step > 255) ? 8'hFF : 8'(int'(prev) + step);
    endfunction

    // Load both stores in random interleaving, sprinkle in ignored beats, then merge.
    task automatic load_and_merge(input int n_first, input int n_second, input bit scrambled);
        logic [7:0] first_sym;
        logic [7:0] second_sym;
        int         i;
        int         j;
        i = 0;
        j = 0;
        first_sym = 8'h00;
        second_sym = 8'h00;
        while (i < n_first || j < n_second) begin
            if ($urandom_range(99) < 5) send_beat(OP_UNUSED, 8'($urandom_range(255)));
            if (j >= n_second || (i < n_first && $urandom_range(1) == 1)) begin
                first_sym = next_symbol(first_sym, scrambled, i == 0);
                send_beat(OP_LOAD_FIRST, first_sym);
                i++;
            end else begin
                second_sym = next_symbol(second_sym, scrambled, j == 0);
                send_beat(OP_LOAD_SECOND, second_sym);
                j++;
            end
        end
        send_beat(OP_RUN, 8'($urandom_range(255)));
    endtask

    // Stimulus: reset, directed beats, then random load and merge sequences.
    initial begin
        int seq;
        int n_first;
        int n_second;
        int pick;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = OP_LOAD_FIRST;
        items_sent = 0;
        quiet = 1'b0;
        hold_off_armed = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty run and an ignored operation.
        send_beat(OP_RUN, 8'hA5);
        send_beat(OP_UNUSED, 8'hFF);
        // Extremes in both stores, with ties at both ends.
        send_beat(OP_LOAD_FIRST, 8'h00);
        send_beat(OP_LOAD_FIRST, 8'h80);
        send_beat(OP_LOAD_FIRST, 8'hFF);
        send_beat(OP_LOAD_SECOND, 8'h00);
        send_beat(OP_LOAD_SECOND, 8'h7F);
        send_beat(OP_LOAD_SECOND, 8'hFF);
        send_beat(OP_RUN, 8'h00);
        // Only one store filled.
        send_beat(OP_LOAD_FIRST, 8'h55);
        send_beat(OP_RUN, 8'hFF);
        send_beat(OP_LOAD_SECOND, 8'hAA);
        send_beat(OP_RUN, 8'h5A);
        // Unsorted contents.
        send_beat(OP_LOAD_FIRST, 8'h09);
        send_beat(OP_LOAD_FIRST, 8'h03);
        send_beat(OP_LOAD_SECOND, 8'h05);
        send_beat(OP_LOAD_SECOND, 8'h01);
        send_beat(OP_RUN, 8'h33);

        seq = 0;
        while (items_sent < TARGET_ITEMS) begin
            pick = $urandom_range(11);
            if (seq == 1) begin
                // Overfill both stores so that extra loads are dropped.
                n_first = STORE_DEPTH + 2;
                n_second = STORE_DEPTH + 1;
            end else if (seq == 2) begin
                n_first = 6;
                n_second = 6;
                hold_off_armed = 1'b1;
            end else if (pick == 0) begin
                n_first = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 2);
                n_second = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 2);
            end else if (pick == 1) begin
                n_first = 0;
                n_second = $urandom_range(6);
            end else if (pick == 2) begin
                n_first = $urandom_range(6);
                n_second = 0;
            end else begin
                n_first = $urandom_range(7);
                n_second = $urandom_range(7);
            end
            quiet = (seq >= 4 && seq <= 8);
            load_and_merge(n_first, n_second, $urandom_range(9) == 0);
            seq++;
        end
        quiet = 1'b0;

        // Drain: wait for every predicted beat, then watch for strays.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off while output is waiting.
    initial begin
        m_axis_tready = 1'b0;
        hold_off_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_armed && !hold_off_done && m_axis_tvalid) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

endmodule

`default_nettype wire
